// ----- rtl/core/rgb565_gray_rotate_downscale_macros.svh -----
// assertion macros for the gray rotate downscale block
`ifndef RGB565_GRAY_ROTATE_DOWNSCALE_MACROS_SVH
`define RGB565_GRAY_ROTATE_DOWNSCALE_MACROS_SVH

// same-cycle implication, off during reset
`define RGRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgrd assertion failed");

// next-cycle implication, off during reset
`define RGRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgrd assertion failed");

// next-cycle implication, checked in and out of reset
`define RGRD_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rgrd assertion failed");

`endif

// ----- rtl/core/rgrd_pkg.sv -----
// types, constants and gray conversion for the gray rotate downscale block
`default_nettype none

package rgrd_pkg;

  localparam int MAX_WIN_WIDTH   = 256;
  localparam int MAX_FRAME_WIDTH = 1024;
  localparam int LINE_DEPTH      = MAX_WIN_WIDTH / 2;
  localparam int LINE_AW         = $clog2(LINE_DEPTH);
  localparam int CFG_DW          = 11;
  localparam int CFG_IW          = 3;

  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_WIN_X       = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_WIN_Y       = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WIN_W       = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_WIN_H       = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_SCALE_MODE  = 3'd5;

  localparam logic [10:0] RST_FRAME_WIDTH = 11'd240;
  localparam logic [9:0]  RST_WIN_X       = 10'd64;
  localparam logic [9:0]  RST_WIN_Y       = 10'd75;
  localparam logic [8:0]  RST_WIN_W       = 9'd120;
  localparam logic [10:0] RST_WIN_H       = 11'd50;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic        start_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [7:0] gray_value;
    logic [7:0] out_row;
    logic [9:0] out_col;
    logic       last_of_frame;
  } result_t;

  // blue from bits 12:8, green from bits 2:0 and 15:13, red dropped
  function automatic logic [7:0] gray_of(input logic [15:0] w);
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] sum;
    blue  = {1'b0, w[12:8], 3'b000};
    green = {1'b0, w[2:0], w[15:13], 2'b00};
    sum   = blue + green;
    return sum[8:1];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgb565_gray_rotate_downscale.sv -----
// Gray conversion, window crop, 90-degree rotation and optional 2x2 averaging of a
// byte-swapped RGB565 pixel stream. One pixel word is taken per clock while
// pixel_stall is low; its result, if any, is registered before it shows on the
// result port. A skid word behind the result register takes the word made while
// the result is stalled; the pixel input then stalls until that word moves up into
// the result register. The 128-entry line buffer of pair sums is read one word
// ahead from the position counters, so the pixel input stalls in the cycle after
// each register write while that read-ahead refreshes. The line buffer has no
// reset and needs no clearing pass.
`default_nettype none

module rgb565_gray_rotate_downscale (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [rgrd_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rgrd_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  rgrd_pkg::pixel_t             pixel,
  output logic                         result_valid,
  input  logic                         result_stall,
  output rgrd_pkg::result_t            result
);
  import rgrd_pkg::*;

  localparam logic [10:0] MAX_STRIDE = 11'(MAX_FRAME_WIDTH);
  localparam logic [8:0]  MAX_WW     = 9'(MAX_WIN_WIDTH);

  logic [10:0] frame_width;
  logic [9:0]  win_x;
  logic [9:0]  win_y;
  logic [8:0]  win_w;
  logic [10:0] win_h;
  logic        scale_mode;
  logic        cfg_hold;

  logic [9:0]  col_count, col_count_next;
  logic [9:0]  row_count, row_count_next;
  logic [7:0]  left_gray_hold;

  logic [8:0]  line_mem [LINE_DEPTH];
  logic [8:0]  line_rd;
  logic [LINE_AW-1:0] rd_addr;

  logic        skid_valid;
  result_t     skid;

  logic        accept;
  logic [10:0] stride;
  logic [8:0]  ww;
  logic [9:0]  cur_col, cur_row, adv_col, adv_row;
  logic [10:0] col_inc;
  logic [9:0]  x, y, x_ahead;
  logic        in_win;
  logic [7:0]  g;
  logic [8:0]  bx, by, bw_m1, bx_row;
  logic [7:0]  bw;
  logic [9:0]  bh, bh_m1;
  logic [9:0]  ww_m1, full_row;
  logic [10:0] wh_m1;
  logic [9:0]  blk_sum;
  logic        res_valid;
  result_t     res;
  logic        hold_we;
  logic        line_we;
  logic [8:0]  line_wd;

  assign accept      = pixel_valid && !pixel_stall;
  assign pixel_stall = skid_valid || cfg_hold;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= RST_FRAME_WIDTH;
      win_x       <= RST_WIN_X;
      win_y       <= RST_WIN_Y;
      win_w       <= RST_WIN_W;
      win_h       <= RST_WIN_H;
      scale_mode  <= 1'b0;
      cfg_hold    <= 1'b0;
    end else begin
      cfg_hold <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH: frame_width <= cfg_data;
          CFG_WIN_X:       win_x       <= cfg_data[9:0];
          CFG_WIN_Y:       win_y       <= cfg_data[9:0];
          CFG_WIN_W:       win_w       <= cfg_data[8:0];
          CFG_WIN_H:       win_h       <= cfg_data;
          CFG_SCALE_MODE:  scale_mode  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // position and window
  always_comb begin
    stride = frame_width;
    if (frame_width == 11'd0) begin
      stride = 11'd1;
    end else if (frame_width > MAX_STRIDE) begin
      stride = MAX_STRIDE;
    end
    ww = (win_w > MAX_WW) ? MAX_WW : win_w;

    cur_col = pixel.start_of_frame ? 10'd0 : col_count;
    cur_row = pixel.start_of_frame ? 10'd0 : row_count;
    col_inc = {1'b0, cur_col} + 11'd1;
    if (col_inc >= stride) begin
      adv_col = 10'd0;
      adv_row = cur_row + 10'd1;
    end else begin
      adv_col = col_inc[9:0];
      adv_row = cur_row;
    end
    col_count_next = accept ? adv_col : col_count;
    row_count_next = accept ? adv_row : row_count;

    // line buffer read ahead for the next word
    x_ahead = col_count_next - win_x;
    rd_addr = x_ahead[LINE_AW:1];

    x      = cur_col - win_x;
    y      = cur_row - win_y;
    in_win = (cur_col >= win_x) && (cur_row >= win_y) &&
             (x < {1'b0, ww}) && ({1'b0, y} < win_h);
    g      = gray_of(pixel.pixel_word);

    ww_m1    = {1'b0, ww} - 10'd1;
    wh_m1    = win_h - 11'd1;
    full_row = ww_m1 - x;

    bx     = x[9:1];
    by     = y[9:1];
    bw     = ww[8:1];
    bh     = win_h[10:1];
    bw_m1  = {1'b0, bw} - 9'd1;
    bh_m1  = bh - 10'd1;
    bx_row = bw_m1 - bx;
    blk_sum = {1'b0, line_rd} + {2'b00, left_gray_hold} + {2'b00, g};
    line_wd = {1'b0, left_gray_hold} + {1'b0, g};

    res_valid = 1'b0;
    hold_we   = 1'b0;
    line_we   = 1'b0;
    res       = '0;
    if (in_win) begin
      if (!scale_mode) begin
        res_valid         = 1'b1;
        res.gray_value    = g;
        res.out_row       = full_row[7:0];
        res.out_col       = y;
        res.last_of_frame = (x == ww_m1) && ({1'b0, y} == wh_m1);
      end else if ((bx < {1'b0, bw}) && ({1'b0, by} < bh)) begin
        if (!x[0]) begin
          hold_we = 1'b1;
        end else if (!y[0]) begin
          line_we = 1'b1;
        end else begin
          res_valid         = 1'b1;
          res.gray_value    = blk_sum[9:2];
          res.out_row       = bx_row[7:0];
          res.out_col       = {1'b0, by};
          res.last_of_frame = (bx == bw_m1) && ({1'b0, by} == bh_m1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count      <= '0;
      row_count      <= '0;
      left_gray_hold <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      if (accept && hold_we) begin
        left_gray_hold <= g;
      end
    end
  end

  // pair sum line buffer
  always_ff @(posedge clk) begin
    if (accept && line_we) begin
      line_mem[bx[LINE_AW-1:0]] <= line_wd;
    end
    line_rd <= line_mem[rd_addr];
  end

  // output register with one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && result_stall) begin
      if (accept && res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else begin
      result_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_stall) begin
      if (accept && res_valid) begin
        skid <= res;
      end
    end else if (skid_valid) begin
      result <= skid;
    end else if (accept && res_valid) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rgrd_checker.sv -----
// port checker for the gray rotate downscale block, with its bind
`default_nettype none

`include "rgb565_gray_rotate_downscale_macros.svh"

module rgrd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_write,
  input logic                         pixel_stall,
  input logic                         result_valid,
  input logic                         result_stall,
  input rgrd_pkg::result_t            result
);
  import rgrd_pkg::*;

  // stalled result word stays put
  `RGRD_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // register write blocks pixel input in the cycle after it
  `RGRD_ASSERT_NXT(a_cfg_stall, cfg_write, pixel_stall)

  // reset leaves nothing pending and input open
  `RGRD_ASSERT_ALWAYS(a_reset_clear, rst, !result_valid && !pixel_stall)

  // input held off only for a pending skid word or a register write
  `RGRD_ASSERT_IMP(a_stall_cause, pixel_stall && !$past(cfg_write), $past(result_valid))

endmodule

bind rgb565_gray_rotate_downscale rgrd_checker u_rgrd_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_write    (cfg_write),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
